>>> src/plu_pkg.sv
// Package for the pixel lens undistortion block.
// Holds the sequencer states, multiply step codes, register indexes and saturation helpers.
// No dependencies.
package plu_pkg;

  localparam logic signed [31:0] Q_ONE = 32'sd268435456;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] OUT_MIN = 20'sh80000;

  localparam int CFG_IW = 4;
  localparam logic [CFG_IW-1:0] CFG_FOCAL_U = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_FOCAL_V = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_CENTER_U = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_CENTER_V = 4'd3;
  localparam logic [CFG_IW-1:0] CFG_K1 = 4'd4;
  localparam logic [CFG_IW-1:0] CFG_K2 = 4'd5;
  localparam logic [CFG_IW-1:0] CFG_P1 = 4'd6;
  localparam logic [CFG_IW-1:0] CFG_P2 = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM_X,
    ST_NORM_Y,
    ST_MUL,
    ST_DIV_X,
    ST_DIV_Y,
    ST_FIN
  } state_t;

  // multiply steps of one round, then the two reprojections
  typedef enum logic [3:0] {
    OP_X2, OP_Y2, OP_R4, OP_K1, OP_K2, OP_XY,
    OP_A, OP_B, OP_C, OP_D, OP_PU, OP_PV
  } op_t;

  // saturate to signed Q4.28 range
  function automatic logic signed [31:0] sat_q(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'(Q_MAX)) r = Q_MAX;
    else if (v < 36'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // saturate to the 20-bit output range
  function automatic logic signed [19:0] sat_out(input logic signed [35:0] v);
    logic signed [19:0] r;
    if (v > 36'(OUT_MAX)) r = OUT_MAX;
    else if (v < 36'(OUT_MIN)) r = OUT_MIN;
    else r = v[19:0];
    return r;
  endfunction

endpackage

>>> src/plu_ifs.sv
// Stream interfaces of the pixel lens undistortion block.
// Depends on nothing; carries valid, ready and payload for each channel.
interface plu_pixel_if;
  logic valid;
  logic ready;
  logic [15:0] pixel_u;
  logic [15:0] pixel_v;
  modport source(output valid, pixel_u, pixel_v, input ready);
  modport sink(input valid, pixel_u, pixel_v, output ready);
endinterface

interface plu_ideal_if;
  logic valid;
  logic ready;
  logic signed [19:0] ideal_u;
  logic signed [19:0] ideal_v;
  logic fault;
  modport source(output valid, ideal_u, ideal_v, fault, input ready);
  modport sink(input valid, ideal_u, ideal_v, fault, output ready);
endinterface

>>> src/plu_mul.sv
// Shared fixed-point multiplier: 32x32 product, then rounded shift by 20 or 28 and saturation.
// Registered product, then registered rounded result; uses plu_pkg.
module plu_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               shift20,
  output logic               done,
  output logic signed [31:0] res
);

  logic               v1;
  logic               sh;
  logic signed [63:0] p;
  logic [63:0]        mag;
  logic [43:0]        rnd;
  logic signed [31:0] res_next;

  // stage one: raw product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= go;
      done <= v1;
    end
    p <= a * b;
    sh <= shift20;
    res <= res_next;
  end

  // stage two: round magnitude, ties away from zero, then saturate
  always_comb begin
    mag = p[63] ? 64'(-p) : 64'(p);
    if (sh) rnd = 44'((mag + 64'd524288) >> 20);
    else rnd = 44'((mag + 64'd134217728) >> 28);
    if (!p[63]) begin
      res_next = (rnd > 44'h07FFFFFFF) ? plu_pkg::Q_MAX : signed'(rnd[31:0]);
    end else begin
      res_next = (rnd > 44'h080000000) ? plu_pkg::Q_MIN : signed'(-rnd[31:0]);
    end
  end

endmodule

>>> src/plu_div.sv
// Shared rounding divider: sat_q(round(value * 2^28 / den)), one quotient bit per cycle.
// Overflow is caught up front so only 33 quotient bits are formed; uses plu_pkg.
module plu_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] value,
  input  logic [30:0]        den,
  output logic               done,
  output logic signed [31:0] res
);

  logic        busy;
  logic [5:0]  cnt;
  logic [30:0] rem;
  logic [32:0] nlo;
  logic [32:0] q;
  logic        neg;
  logic [30:0] d;
  logic [31:0] vmag;
  logic [59:0] num;
  logic        ovf;
  logic [31:0] trial;
  logic        take;
  logic [32:0] qn;
  logic signed [31:0] fin;

  always_comb begin
    vmag = value[31] ? 32'(-value) : 32'(value);
    num = {vmag, 28'd0} + 60'(den >> 1);
    ovf = {4'd0, num} >= {den, 33'd0};
    trial = {rem, nlo[32]};
    take = trial >= {1'b0, d};
    qn = {q[31:0], take};
    if (!neg) fin = (qn > 33'h07FFFFFFF) ? plu_pkg::Q_MAX : signed'(qn[31:0]);
    else fin = (qn > 33'h080000000) ? plu_pkg::Q_MIN : signed'(-qn[31:0]);
  end

  // launch, iterate, and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        neg <= value[31];
        d <= den;
        rem <= num[59:33] + 31'd0;
        nlo <= num[32:0];
        q <= '0;
        cnt <= '0;
        if (ovf) begin
          done <= 1'b1;
          res <= value[31] ? plu_pkg::Q_MIN : plu_pkg::Q_MAX;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? 31'(trial - {1'b0, d}) : trial[30:0];
        nlo <= {nlo[31:0], 1'b0};
        q <= qn;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
          res <= fin;
        end
      end
    end
  end

endmodule

>>> src/pixel_lens_undistortion.sv
// Pixel lens undistortion: one result per input transaction.
// Steps: two normalising divisions, then per round ten multiplies and two divisions on the
// shared units until the estimate converges or MAX_ITER rounds are done, then two reprojection
// multiplies and a load of the output register; a non-positive radial factor ends in a fault.
// Throughput: one item at a time, rounds <= MAX_ITER; input ready only while the sequencer is idle.
// Synchronous active-high reset clears control and restores the register defaults.
module pixel_lens_undistortion #(
  parameter int MAX_ITER = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [plu_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [23:0]                  cfg_data,
  plu_pixel_if.sink                    pixel_in,
  plu_ideal_if.source                  ideal_out
);

  localparam int RW = $clog2(MAX_ITER + 1);

  plu_pkg::state_t state, state_next;
  plu_pkg::op_t    op;

  logic [15:0] focal_u, focal_v, center_u, center_v;
  logic signed [23:0] radial_k1, radial_k2, tangential_p1, tangential_p2;

  logic [15:0] pix_u, pix_v;
  logic signed [31:0] dist_x, dist_y, x, y, x2, y2, r2, r4, t1, radial;
  logic signed [31:0] xy2, ta, dxt, tc, dyt, nx;
  logic signed [19:0] res_u, res_v;
  logic [RW-1:0] round_cnt;
  logic pend, fault;

  logic [15:0] fu, fv;
  logic rad_bad, conv, last;
  logic in_acc, fin_go;

  logic mul_go, mul_done, mul_sh20;
  logic signed [31:0] mul_a, mul_b, mul_res;
  logic div_go, div_done;
  logic signed [31:0] div_val, div_res;
  logic [30:0] div_den;
  logic signed [32:0] ex, ey;

  assign fu = (focal_u == 16'd0) ? 16'd1 : focal_u;
  assign fv = (focal_v == 16'd0) ? 16'd1 : focal_v;
  assign rad_bad = radial[31] || (radial == 32'sd0);
  assign in_acc = pixel_in.valid && pixel_in.ready;
  assign fin_go = (state == plu_pkg::ST_FIN) && (!ideal_out.valid || ideal_out.ready);
  assign ex = 33'(nx) - 33'(x);
  assign ey = 33'(div_res) - 33'(y);
  assign conv = (ex >= -33'sd1) && (ex <= 33'sd1) && (ey >= -33'sd1) && (ey <= 33'sd1);
  assign last = (round_cnt == RW'(MAX_ITER - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_u <= 16'd8000;
      focal_v <= 16'd8000;
      center_u <= 16'd5120;
      center_v <= 16'd3840;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plu_pkg::CFG_FOCAL_U: focal_u <= cfg_data[15:0];
        plu_pkg::CFG_FOCAL_V: focal_v <= cfg_data[15:0];
        plu_pkg::CFG_CENTER_U: center_u <= cfg_data[15:0];
        plu_pkg::CFG_CENTER_V: center_v <= cfg_data[15:0];
        plu_pkg::CFG_K1: radial_k1 <= signed'(cfg_data);
        plu_pkg::CFG_K2: radial_k2 <= signed'(cfg_data);
        plu_pkg::CFG_P1: tangential_p1 <= signed'(cfg_data);
        plu_pkg::CFG_P2: tangential_p2 <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      plu_pkg::ST_IDLE: if (in_acc) state_next = plu_pkg::ST_NORM_X;
      plu_pkg::ST_NORM_X: if (div_done) state_next = plu_pkg::ST_NORM_Y;
      plu_pkg::ST_NORM_Y: if (div_done) state_next = plu_pkg::ST_MUL;
      plu_pkg::ST_MUL: begin
        if (!pend && op == plu_pkg::OP_XY && rad_bad) state_next = plu_pkg::ST_FIN;
        else if (mul_done && op == plu_pkg::OP_D) state_next = plu_pkg::ST_DIV_X;
        else if (mul_done && op == plu_pkg::OP_PV) state_next = plu_pkg::ST_FIN;
      end
      plu_pkg::ST_DIV_X: if (div_done) state_next = plu_pkg::ST_DIV_Y;
      plu_pkg::ST_DIV_Y: if (div_done) state_next = plu_pkg::ST_MUL;
      plu_pkg::ST_FIN: if (fin_go) state_next = plu_pkg::ST_IDLE;
      default: state_next = plu_pkg::ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    pixel_in.ready = (state == plu_pkg::ST_IDLE);
    mul_go = (state == plu_pkg::ST_MUL) && !pend && !(op == plu_pkg::OP_XY && rad_bad);
    div_go = !pend && (state inside {plu_pkg::ST_NORM_X, plu_pkg::ST_NORM_Y,
                                     plu_pkg::ST_DIV_X, plu_pkg::ST_DIV_Y});
    mul_a = x;
    mul_b = x;
    mul_sh20 = 1'b0;
    case (op)
      plu_pkg::OP_X2: begin mul_a = x; mul_b = x; end
      plu_pkg::OP_Y2: begin mul_a = y; mul_b = y; end
      plu_pkg::OP_R4: begin mul_a = r2; mul_b = r2; end
      plu_pkg::OP_K1: begin mul_a = 32'(radial_k1); mul_b = r2; mul_sh20 = 1'b1; end
      plu_pkg::OP_K2: begin mul_a = 32'(radial_k2); mul_b = r4; mul_sh20 = 1'b1; end
      plu_pkg::OP_XY: begin mul_a = x; mul_b = y; end
      plu_pkg::OP_A: begin mul_a = 32'(tangential_p1); mul_b = xy2; mul_sh20 = 1'b1; end
      plu_pkg::OP_B: begin
        mul_a = 32'(tangential_p2);
        mul_b = plu_pkg::sat_q(36'(r2) + 36'(x2) + 36'(x2));
        mul_sh20 = 1'b1;
      end
      plu_pkg::OP_C: begin
        mul_a = 32'(tangential_p1);
        mul_b = plu_pkg::sat_q(36'(r2) + 36'(y2) + 36'(y2));
        mul_sh20 = 1'b1;
      end
      plu_pkg::OP_D: begin mul_a = 32'(tangential_p2); mul_b = xy2; mul_sh20 = 1'b1; end
      plu_pkg::OP_PU: begin mul_a = x; mul_b = signed'({16'd0, fu}); end
      plu_pkg::OP_PV: begin mul_a = y; mul_b = signed'({16'd0, fv}); end
      default: ;
    endcase
    div_val = 32'(signed'({1'b0, pix_u}) - signed'({1'b0, center_u}));
    div_den = {15'd0, fu};
    case (state)
      plu_pkg::ST_NORM_Y: begin
        div_val = 32'(signed'({1'b0, pix_v}) - signed'({1'b0, center_v}));
        div_den = {15'd0, fv};
      end
      plu_pkg::ST_DIV_X: begin
        div_val = plu_pkg::sat_q(36'(dist_x) - 36'(dxt));
        div_den = radial[30:0];
      end
      plu_pkg::ST_DIV_Y: begin
        div_val = plu_pkg::sat_q(36'(dist_y) - 36'(dyt));
        div_den = radial[30:0];
      end
      default: ;
    endcase
  end

  // sequencer registers and datapath captures
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plu_pkg::ST_IDLE;
      pend <= 1'b0;
      op <= plu_pkg::OP_X2;
      ideal_out.valid <= 1'b0;
      fault <= 1'b0;
      round_cnt <= '0;
    end else begin
      state <= state_next;
      if (mul_go || div_go) pend <= 1'b1;
      else if (mul_done || div_done) pend <= 1'b0;
      if (in_acc) begin
        pix_u <= pixel_in.pixel_u;
        pix_v <= pixel_in.pixel_v;
        fault <= 1'b0;
        round_cnt <= '0;
      end
      if (state == plu_pkg::ST_MUL && !pend && op == plu_pkg::OP_XY && rad_bad) fault <= 1'b1;
      if (div_done) begin
        unique case (state)
          plu_pkg::ST_NORM_X: begin dist_x <= div_res; x <= div_res; end
          plu_pkg::ST_NORM_Y: begin dist_y <= div_res; y <= div_res; op <= plu_pkg::OP_X2; end
          plu_pkg::ST_DIV_X: nx <= div_res;
          plu_pkg::ST_DIV_Y: begin
            x <= nx;
            y <= div_res;
            round_cnt <= round_cnt + RW'(1);
            op <= (conv || last) ? plu_pkg::OP_PU : plu_pkg::OP_X2;
          end
          default: ;
        endcase
      end
      if (mul_done) begin
        if (op != plu_pkg::OP_PV) op <= plu_pkg::op_t'(op + 4'd1);
        case (op)
          plu_pkg::OP_X2: x2 <= mul_res;
          plu_pkg::OP_Y2: begin y2 <= mul_res; r2 <= plu_pkg::sat_q(36'(x2) + 36'(mul_res)); end
          plu_pkg::OP_R4: r4 <= mul_res;
          plu_pkg::OP_K1: t1 <= mul_res;
          plu_pkg::OP_K2: radial <= plu_pkg::sat_q(36'(plu_pkg::Q_ONE) + 36'(t1)
                                                    + 36'(mul_res));
          plu_pkg::OP_XY: xy2 <= plu_pkg::sat_q(36'(mul_res) + 36'(mul_res));
          plu_pkg::OP_A: ta <= mul_res;
          plu_pkg::OP_B: dxt <= plu_pkg::sat_q(36'(ta) + 36'(mul_res));
          plu_pkg::OP_C: tc <= mul_res;
          plu_pkg::OP_D: dyt <= plu_pkg::sat_q(36'(tc) + 36'(mul_res));
          plu_pkg::OP_PU: res_u <= plu_pkg::sat_out(36'(mul_res) + 36'({1'b0, center_u}));
          plu_pkg::OP_PV: res_v <= plu_pkg::sat_out(36'(mul_res) + 36'({1'b0, center_v}));
          default: ;
        endcase
      end
      // load the output register, or drop the taken transaction
      if (fin_go) begin
        ideal_out.valid <= 1'b1;
        ideal_out.ideal_u <= fault ? 20'sd0 : res_u;
        ideal_out.ideal_v <= fault ? 20'sd0 : res_v;
        ideal_out.fault <= fault;
      end else if (ideal_out.ready) begin
        ideal_out.valid <= 1'b0;
      end
    end
  end

  plu_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .shift20(mul_sh20), .done(mul_done), .res(mul_res)
  );

  plu_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .value(div_val), .den(div_den),
    .done(div_done), .res(div_res)
  );

endmodule

>>> src/plu_checker.sv
// Port-level checker for the pixel lens undistortion block, with its bind.
// Depends on the top level's ports only.
module plu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [19:0] ideal_u,
  input logic signed [19:0] ideal_v,
  input logic               fault
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // a faulted result carries zero coordinates
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> ideal_u == 20'sd0 && ideal_v == 20'sd0)
    else $error("fault result not zero");

  // stop taking input once an item is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result appears right after a reset cycle
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixel_lens_undistortion plu_checker u_plu_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(pixel_in.valid),
  .in_ready(pixel_in.ready),
  .out_valid(ideal_out.valid),
  .out_ready(ideal_out.ready),
  .ideal_u(ideal_out.ideal_u),
  .ideal_v(ideal_out.ideal_v),
  .fault(ideal_out.fault)
);
